FILE: src/ipv4_tcp_checksum_engine_defines.svh
// ----------------------------------------------------------------------------
// IPv4/TCP checksum engine assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef IPV4_TCP_CHECKSUM_ENGINE_DEFINES_SVH
`define IPV4_TCP_CHECKSUM_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ITCE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("checksum engine assertion failed");
`define ITCE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("checksum engine assertion failed");
`else
`define ITCE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define ITCE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

FILE: src/itce_pkg.sv
// ----------------------------------------------------------------------------
// IPv4/TCP checksum engine package
// Constants, the result type and the ones'-complement fold shared by the RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package itce_pkg;

    localparam int unsigned IDX_W  = 15;

    localparam logic [IDX_W-1:0] IDX_MAX       = 15'h7FFF;
    localparam logic [IDX_W-1:0] HDR_CKSUM_IDX = 15'd5;
    localparam logic [IDX_W-1:0] TCP_CKSUM_OFS = 15'd8;
    localparam logic [IDX_W-1:0] ADDR_FIRST    = 15'd6;
    localparam logic [IDX_W-1:0] ADDR_LAST     = 15'd9;
    localparam logic [3:0]       MIN_IHL       = 4'd5;
    localparam logic [15:0]      TCP_PROTO     = 16'd6;

    typedef struct packed {
        logic [15:0] ip_header_checksum;
        logic [15:0] tcp_checksum;
        logic        length_mismatch;
    } itce_result_t;

    // Folds a sum of up to eight 16-bit terms back to 16 bits with
    // end-around carry. The result is zero only when the sum is zero.
    function automatic logic [15:0] oc_fold(input logic [18:0] s);
        logic [16:0] f1;
        logic [16:0] f2;
        f1 = {1'b0, s[15:0]} + {14'd0, s[18:16]};
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
        return f2[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/itce_accum.sv
// ----------------------------------------------------------------------------
// IPv4/TCP checksum accumulator
// Per-word header and segment sums, packet length tracking and the final
// checksum and mismatch values for the word that closes a packet.
// ----------------------------------------------------------------------------
`default_nettype none

module itce_accum
    import itce_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic [15:0]   word,
    input  wire logic          last,
    output itce_result_t       result
);

    logic [IDX_W-1:0] word_index_reg,    word_index_next;
    logic [15:0]      header_sum_reg,    header_sum_next;
    logic [15:0]      segment_sum_reg,   segment_sum_next;
    logic [3:0]       header_words_reg,  header_words_next;
    logic [15:0]      packet_length_reg, packet_length_next;
    logic             overrun_reg,       overrun_next;

    logic             is_first;
    logic             is_second;
    logic [3:0]       hw;
    logic [15:0]      pl;
    logic [4:0]       hw2;
    logic [5:0]       hbytes;
    logic             in_len;
    logic             in_hdr;
    logic [15:0]      v;
    logic [15:0]      hdr_term;
    logic [15:0]      seg_term;
    logic [15:0]      addr_term;
    logic [15:0]      seg_len;
    logic [16:0]      need_words;
    logic [15:0]      header_sum_new;
    logic [15:0]      segment_sum_new;
    logic [15:0]      tcp_sum;

    always_comb
    begin
        is_first  = (word_index_reg == '0);
        is_second = (word_index_reg == IDX_W'(1));
        // IHL and total length are used in the same cycle they arrive.
        hw        = is_first  ? word[11:8] : header_words_reg;
        pl        = is_second ? word       : packet_length_reg;
        hw2       = {hw, 1'b0};
        hbytes    = {hw, 2'b00};

        in_len = !overrun_reg && (is_first || ({word_index_reg, 1'b0} < pl));
        v      = ({word_index_reg, 1'b1} == pl) ? {word[15:8], 8'h00} : word;
        in_hdr = (word_index_reg < {10'd0, hw2});

        hdr_term  = (in_len && in_hdr && (word_index_reg != HDR_CKSUM_IDX)) ? v : 16'd0;
        seg_term  = (in_len && !in_hdr &&
                     (word_index_reg != ({10'd0, hw2} + TCP_CKSUM_OFS))) ? v : 16'd0;
        addr_term = (in_len && (word_index_reg >= ADDR_FIRST) &&
                     (word_index_reg <= ADDR_LAST)) ? v : 16'd0;

        seg_len = (pl >= {10'd0, hbytes}) ? (pl - {10'd0, hbytes}) : 16'd0;

        header_sum_new  = oc_fold({3'd0, header_sum_reg} + {3'd0, hdr_term});
        segment_sum_new = oc_fold({3'd0, segment_sum_reg} + {3'd0, seg_term}
                                  + {3'd0, addr_term});
        // Pseudo-header length and protocol join the running sum in one fold.
        tcp_sum = oc_fold({3'd0, segment_sum_reg} + {3'd0, seg_term} + {3'd0, addr_term}
                          + {3'd0, seg_len} + {3'd0, TCP_PROTO});

        need_words = {1'b0, word_index_reg, 1'b0} + 17'd2;

        result.ip_header_checksum = ~header_sum_new;
        result.tcp_checksum       = ~tcp_sum;
        result.length_mismatch    = (hw < MIN_IHL) || is_first ||
                                    (!overrun_reg && (need_words < {1'b0, pl}));
    end

    always_comb
    begin
        word_index_next    = word_index_reg;
        header_sum_next    = header_sum_reg;
        segment_sum_next   = segment_sum_reg;
        header_words_next  = header_words_reg;
        packet_length_next = packet_length_reg;
        overrun_next       = overrun_reg;
        if (en)
        begin
            if (last)
            begin
                word_index_next    = '0;
                header_sum_next    = '0;
                segment_sum_next   = '0;
                header_words_next  = '0;
                packet_length_next = '0;
                overrun_next       = 1'b0;
            end
            else
            begin
                header_sum_next    = header_sum_new;
                segment_sum_next   = segment_sum_new;
                header_words_next  = hw;
                packet_length_next = pl;
                if (word_index_reg == IDX_MAX)
                begin
                    overrun_next = 1'b1;
                end
                else
                begin
                    word_index_next = word_index_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_index_reg    <= '0;
            header_sum_reg    <= '0;
            segment_sum_reg   <= '0;
            header_words_reg  <= '0;
            packet_length_reg <= '0;
            overrun_reg       <= 1'b0;
        end
        else
        begin
            word_index_reg    <= word_index_next;
            header_sum_reg    <= header_sum_next;
            segment_sum_reg   <= segment_sum_next;
            header_words_reg  <= header_words_next;
            packet_length_reg <= packet_length_next;
            overrun_reg       <= overrun_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/ipv4_tcp_checksum_engine.sv
// ----------------------------------------------------------------------------
// IPv4 header and TCP checksum engine
// Computes the IPv4 header checksum and the TCP checksum over the segment
// and pseudo-header of a packet streamed in as 16-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one packet word per cycle while s_axis_tready is
//   high, first byte in tdata[15:8]; tlast marks the final word of the packet.
//   A word that closes a packet produces one result word on the master
//   channel in the next cycle: the header checksum in tdata[15:0], the TCP
//   checksum in tdata[31:16] and a length-mismatch flag in tuser.
//   All other words produce no result.
//   Throughput is one word per cycle while s_axis_tready is high, with no
//   gaps between packets; each word needs only an end-around add into the
//   running-sum registers, and a closing word's sums go to the result register.
//   s_axis_tready drops only while a result is held and m_axis_tready is
//   low, so a stalled receiver holds the input after at most one packet.
//   Reset clears the running sums, the word count and the result valid flag;
//   the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ipv4_tcp_checksum_engine_defines.svh"

module ipv4_tcp_checksum_engine
    import itce_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [15:0]   s_axis_tdata,   // [15:0] word
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [31:0]        m_axis_tdata,   // [15:0] ip_header_checksum,
                                               // [31:16] tcp_checksum
    output logic               m_axis_tuser    // [0] length_mismatch
);

    logic         s_acc;
    itce_result_t acc_result;
    logic         out_valid_reg, out_valid_next;
    itce_result_t out_data_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    itce_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (s_acc),
        .word   (s_axis_tdata),
        .last   (s_axis_tlast),
        .result (acc_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s_acc && s_axis_tlast)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc && s_axis_tlast)
        begin
            out_data_reg <= acc_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.tcp_checksum, out_data_reg.ip_header_checksum};
    assign m_axis_tuser  = out_data_reg.length_mismatch;

    // A closing word always leaves a result behind it.
    `ITCE_ASSERT_NXT(a_last_gives_result, clk, rst_n, s_acc && s_axis_tlast, out_valid_reg)
    // Words inside a packet never create a result.
    `ITCE_ASSERT_NXT(a_mid_word_silent, clk, rst_n,
                     s_acc && !s_axis_tlast && !out_valid_reg, !out_valid_reg)
    // A new result only follows an accepted closing word.
    `ITCE_ASSERT_IMP(a_result_source, clk, rst_n, $rose(out_valid_reg),
                     $past(s_acc && s_axis_tlast))
    // The pseudo-header protocol term keeps the TCP sum nonzero.
    `ITCE_ASSERT_IMP(a_tcp_sum_nonzero, clk, rst_n, m_axis_tvalid,
                     m_axis_tdata[31:16] != 16'hFFFF)

endmodule

`default_nettype wire
